@@ hdl/tfp_pkg.sv @@
`default_nettype none

package tfp_pkg;

  // Field widths
  localparam int ORG_W     = 32;
  localparam int DIR_W     = 18;
  localparam int THR_W     = 31;

  // Exact intermediate widths
  localparam int SUM_W     = ORG_W + 1;          // origin difference and sum
  localparam int PRD_W     = DIR_W + SUM_W;      // direction times offset
  localparam int AB_W      = PRD_W + 2;          // dot product of three terms
  localparam int CP_W      = 2 * DIR_W;          // direction times direction
  localparam int C_W       = CP_W + 2;           // c, Q32
  localparam int CLO_W     = 19;                 // low chunk of c
  localparam int CC_W      = CLO_W + 1 + C_W;    // partial of c*c
  localparam int CX_W      = CLO_W + 1 + AB_W;   // partial of c*a and c*b
  localparam int DEN_W     = 76;                 // c*c - 1, Q64
  localparam int NUM_W     = 92;                 // numerators, Q64
  localparam int DCH_W     = 26;                 // chunk of the denominator
  localparam int NCH_W     = 31;                 // chunk of a numerator
  localparam int NTOP_W    = NUM_W - 2 * NCH_W;  // signed top chunk of a numerator
  localparam int PD_W      = SUM_W + DCH_W + 1;
  localparam int PN_W      = NCH_W + 1 + DIR_W;
  localparam int S_W       = 112;                // scaled point sum
  localparam int REM_W     = 110;                // dividend and remainder
  localparam int DVS_W     = DEN_W + 1;          // divisor, twice the denominator
  localparam int Q_W       = 32;                 // quotient bits kept

  localparam int ONE_SHIFT = 64;                 // 1.0 in Q64
  localparam int AB_SHIFT  = 32;                 // Q32 to Q64
  localparam int THR_SHIFT = 34;                 // threshold units 2^-30 to Q64

  // Pipeline depth: setup stages, one stage per quotient bit, result stage
  localparam int NSTG      = 12 + Q_W;

  // Configuration port
  localparam int PADDR_W   = 2;
  localparam int APB_W     = 32;
  localparam logic [PADDR_W-1:0] REG_THR = '0;
  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1074);

  localparam logic signed [ORG_W-1:0] SAT_POS = 32'sh7fff_ffff;
  localparam logic signed [ORG_W-1:0] SAT_NEG = 32'sh8000_0000;

  typedef logic signed [ORG_W-1:0] org_t;
  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [PRD_W-1:0] prd_t;
  typedef logic signed [AB_W-1:0]  ab_t;
  typedef logic signed [CP_W-1:0]  cp_t;
  typedef logic signed [C_W-1:0]   c_t;
  typedef logic signed [CC_W-1:0]  cc_t;
  typedef logic signed [CX_W-1:0]  cx_t;
  typedef logic signed [DEN_W-1:0] den_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [PD_W-1:0]  pd_t;
  typedef logic signed [PN_W-1:0]  pn_t;
  typedef logic signed [S_W-1:0]   s_t;

endpackage

`default_nettype wire

@@ hdl/two_ray_fixation_point.sv @@
// Two-ray fixation point: midpoint of the closest points of two rays.
// Input channel (in_valid/in_ready) carries one ray pair per transfer:
// origins in signed Q16.16, directions in signed Q1.16. Output channel
// (out_valid/out_ready) carries one point per input, saturated Q16.16, with
// point_valid low and the coordinates zero when |c*c - 1| is zero or below
// parallel_threshold (APB register 0). Throughput: one item per cycle while
// the skid register is empty; the depth is set by the 32-stage restoring
// divider (one quotient bit per stage) that follows eleven multiply/add stages,
// with wide products split into partials of at most 20 by 53 bits.
// Stall: the whole pipeline advances together; a skid register behind the
// output register catches the item in flight. While a result waits, transfers
// continue until the next result reaches the end of the pipeline and moves
// into the skid; in_ready then drops until the skid drains.
// Reset (synchronous, rst high) empties the pipeline and output and restores
// the threshold to 1074. Write the threshold only while the block is idle.
`default_nettype none

module two_ray_fixation_point (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfp_pkg::PADDR_W-1:0]   paddr,
  input  logic [tfp_pkg::APB_W-1:0]     pwdata,
  output logic [tfp_pkg::APB_W-1:0]     prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tfp_pkg::org_t                 left_origin_x,
  input  tfp_pkg::org_t                 left_origin_y,
  input  tfp_pkg::org_t                 left_origin_z,
  input  tfp_pkg::dir_t                 left_dir_x,
  input  tfp_pkg::dir_t                 left_dir_y,
  input  tfp_pkg::dir_t                 left_dir_z,
  input  tfp_pkg::org_t                 right_origin_x,
  input  tfp_pkg::org_t                 right_origin_y,
  input  tfp_pkg::org_t                 right_origin_z,
  input  tfp_pkg::dir_t                 right_dir_x,
  input  tfp_pkg::dir_t                 right_dir_y,
  input  tfp_pkg::dir_t                 right_dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tfp_pkg::org_t                 point_x,
  output tfp_pkg::org_t                 point_y,
  output tfp_pkg::org_t                 point_z,
  output logic                          point_valid
);
  import tfp_pkg::*;

  logic [THR_W-1:0] thr;
  logic             en;
  logic             skid_valid;
  logic [NSTG-1:0]  vld;

  org_t ol_in [3];
  org_t or_in [3];
  dir_t zl_in [3];
  dir_t zr_in [3];

  // Stage 1
  sum_t w1 [3], sm1 [3];
  dir_t zl1 [3], zr1 [3];
  // Stage 2
  prd_t pa2 [3], pb2 [3];
  cp_t  pc2 [3];
  sum_t sm2 [3];
  dir_t zl2 [3], zr2 [3];
  // Stage 3
  ab_t  a3, b3;
  c_t   c3;
  sum_t sm3 [3];
  dir_t zl3 [3], zr3 [3];
  // Stage 4
  cc_t  cch4, ccl4;
  cx_t  cbh4, cbl4, cah4, cal4;
  ab_t  a4, b4;
  sum_t sm4 [3];
  dir_t zl4 [3], zr4 [3];
  // Stage 5
  den_t den5;
  num_t nl5, nr5;
  sum_t sm5 [3];
  dir_t zl5 [3], zr5 [3];
  // Stage 6
  logic [DEN_W-1:0] den_abs;
  logic             par_c;
  logic [DEN_W-1:0] den6;
  logic             par6;
  num_t             nl6, nr6;
  sum_t             sm6 [3];
  dir_t             zl6 [3], zr6 [3];
  // Stage 7
  logic [3*DCH_W-1:0] den_x;
  pd_t  pd7 [3][3];
  pn_t  pl7 [3][3], pr7 [3][3];
  logic [DEN_W-1:0] den7;
  logic             par7;
  // Stage 8
  s_t   p08 [3], p18 [3], p28 [3];
  logic [DEN_W-1:0] den8;
  logic             par8;
  // Stage 9
  s_t   s9 [3];
  logic [DEN_W-1:0] den9;
  logic             par9;
  // Stage 10
  logic [REM_W-1:0] rem10 [3];
  logic             sgn10 [3];
  logic [DVS_W-1:0] dvs10;
  logic             par10;
  // Stage 11 and divider steps
  logic [REM_W-1:0] drem [0:Q_W][3];
  logic [Q_W-1:0]   dq   [0:Q_W][3];
  logic             dovf [0:Q_W][3];
  logic             dsgn [0:Q_W][3];
  logic [DVS_W-1:0] dvs  [0:Q_W];
  logic             dpar [0:Q_W];
  // Result stage and skid
  org_t fin_pt [3];
  logic fin_ok;
  org_t sk_pt [3];
  logic sk_ok;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_THR) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_THR) ? APB_W'(thr) : '0;

  // Advance the pipeline whenever the skid is free
  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  assign ol_in = '{left_origin_x, left_origin_y, left_origin_z};
  assign or_in = '{right_origin_x, right_origin_y, right_origin_z};
  assign zl_in = '{left_dir_x, left_dir_y, left_dir_z};
  assign zr_in = '{right_dir_x, right_dir_y, right_dir_z};

  // Stages 1 to 5: offsets, dot products, c*c - 1 and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 3; ax++) begin
        w1[ax]  <= sum_t'(ol_in[ax]) - sum_t'(or_in[ax]);
        sm1[ax] <= sum_t'(ol_in[ax]) + sum_t'(or_in[ax]);
        zl1[ax] <= zl_in[ax];
        zr1[ax] <= zr_in[ax];

        pa2[ax] <= zl1[ax] * w1[ax];
        pb2[ax] <= zr1[ax] * w1[ax];
        pc2[ax] <= zl1[ax] * zr1[ax];
        sm2[ax] <= sm1[ax];
        zl2[ax] <= zl1[ax];
        zr2[ax] <= zr1[ax];

        sm3[ax] <= sm2[ax];
        zl3[ax] <= zl2[ax];
        zr3[ax] <= zr2[ax];

        sm4[ax] <= sm3[ax];
        zl4[ax] <= zl3[ax];
        zr4[ax] <= zr3[ax];

        sm5[ax] <= sm4[ax];
        zl5[ax] <= zl4[ax];
        zr5[ax] <= zr4[ax];
      end

      a3 <= ab_t'(pa2[0]) + ab_t'(pa2[1]) + ab_t'(pa2[2]);
      b3 <= ab_t'(pb2[0]) + ab_t'(pb2[1]) + ab_t'(pb2[2]);
      c3 <= c_t'(pc2[0]) + c_t'(pc2[1]) + c_t'(pc2[2]);

      // split c into a signed high and an unsigned low chunk
      cch4 <= $signed(c3[C_W-1:CLO_W]) * c3;
      ccl4 <= $signed({1'b0, c3[CLO_W-1:0]}) * c3;
      cbh4 <= $signed(c3[C_W-1:CLO_W]) * b3;
      cbl4 <= $signed({1'b0, c3[CLO_W-1:0]}) * b3;
      cah4 <= $signed(c3[C_W-1:CLO_W]) * a3;
      cal4 <= $signed({1'b0, c3[CLO_W-1:0]}) * a3;
      a4   <= a3;
      b4   <= b3;

      den5 <= (den_t'(cch4) <<< CLO_W) + den_t'(ccl4) - (den_t'(1) <<< ONE_SHIFT);
      nl5  <= (num_t'(a4) <<< AB_SHIFT) - (num_t'(cbh4) <<< CLO_W) - num_t'(cbl4);
      nr5  <= (num_t'(cah4) <<< CLO_W) + num_t'(cal4) - (num_t'(b4) <<< AB_SHIFT);
    end
  end

  // Near-parallel test on |c*c - 1|
  always_comb begin
    den_abs = den5[DEN_W-1] ? DEN_W'(-den5) : DEN_W'(den5);
    par_c   = (den5 == '0) || (den_abs < (DEN_W'(thr) << THR_SHIFT));
  end

  assign den_x = (3*DCH_W)'(den6);

  // Stages 6 to 10: sign fold, partial products, point sums, dividend
  always_ff @(posedge clk) begin
    if (en) begin
      den6 <= den_abs;
      par6 <= par_c;
      nl6  <= den5[DEN_W-1] ? -nl5 : nl5;
      nr6  <= den5[DEN_W-1] ? -nr5 : nr5;
      for (int ax = 0; ax < 3; ax++) begin
        sm6[ax] <= sm5[ax];
        zl6[ax] <= zl5[ax];
        zr6[ax] <= zr5[ax];
      end

      den7 <= den6;
      par7 <= par6;
      for (int ax = 0; ax < 3; ax++) begin
        for (int k = 0; k < 3; k++) begin
          pd7[ax][k] <= sm6[ax] * $signed({1'b0, den_x[k*DCH_W +: DCH_W]});
        end
        for (int k = 0; k < 2; k++) begin
          pl7[ax][k] <= zl6[ax] * $signed({1'b0, nl6[k*NCH_W +: NCH_W]});
          pr7[ax][k] <= zr6[ax] * $signed({1'b0, nr6[k*NCH_W +: NCH_W]});
        end
        pl7[ax][2] <= zl6[ax] * $signed(nl6[NUM_W-1:2*NCH_W]);
        pr7[ax][2] <= zr6[ax] * $signed(nr6[NUM_W-1:2*NCH_W]);
      end

      den8 <= den7;
      par8 <= par7;
      for (int ax = 0; ax < 3; ax++) begin
        p08[ax] <= s_t'(pd7[ax][0]) + (s_t'(pd7[ax][1]) <<< DCH_W)
                   + (s_t'(pd7[ax][2]) <<< (2*DCH_W));
        p18[ax] <= s_t'(pl7[ax][0]) + (s_t'(pl7[ax][1]) <<< NCH_W)
                   + (s_t'(pl7[ax][2]) <<< (2*NCH_W));
        p28[ax] <= s_t'(pr7[ax][0]) + (s_t'(pr7[ax][1]) <<< NCH_W)
                   + (s_t'(pr7[ax][2]) <<< (2*NCH_W));
      end

      den9 <= den8;
      par9 <= par8;
      for (int ax = 0; ax < 3; ax++) begin
        s9[ax] <= p08[ax] + p18[ax] + p28[ax];
      end

      // dividend is |s| + den, rounding to nearest with ties away from zero
      dvs10 <= {den9, 1'b0};
      par10 <= par9;
      for (int ax = 0; ax < 3; ax++) begin
        sgn10[ax] <= s9[ax][S_W-1];
        rem10[ax] <= s9[ax][S_W-1] ? REM_W'(s_t'(den9) - s9[ax])
                                   : REM_W'(s9[ax] + s_t'(den9));
      end

      // stage 11: flag quotients that cannot fit in the kept bits
      dvs[0]  <= dvs10;
      dpar[0] <= par10;
      for (int ax = 0; ax < 3; ax++) begin
        drem[0][ax] <= rem10[ax];
        dq[0][ax]   <= '0;
        dsgn[0][ax] <= sgn10[ax];
        dovf[0][ax] <= rem10[ax] >= (REM_W'(dvs10) << Q_W);
      end
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dvs[k]  <= dvs[k-1];
        dpar[k] <= dpar[k-1];
        for (int ax = 0; ax < 3; ax++) begin
          dsgn[k][ax] <= dsgn[k-1][ax];
          dovf[k][ax] <= dovf[k-1][ax];
          if (drem[k-1][ax] >= (REM_W'(dvs[k-1]) << (Q_W - k))) begin
            drem[k][ax] <= drem[k-1][ax] - (REM_W'(dvs[k-1]) << (Q_W - k));
            dq[k][ax]   <= dq[k-1][ax] | (Q_W'(1) << (Q_W - k));
          end else begin
            drem[k][ax] <= drem[k-1][ax];
            dq[k][ax]   <= dq[k-1][ax];
          end
        end
      end
    end
  end

  // Result stage: sign, saturate, zero for near-parallel rays
  always_ff @(posedge clk) begin
    if (en) begin
      fin_ok <= !dpar[Q_W];
      for (int ax = 0; ax < 3; ax++) begin
        priority if (dpar[Q_W]) begin
          fin_pt[ax] <= '0;
        end else if (dovf[Q_W][ax] || dq[Q_W][ax][Q_W-1]) begin
          fin_pt[ax] <= dsgn[Q_W][ax] ? SAT_NEG : SAT_POS;
        end else begin
          fin_pt[ax] <= dsgn[Q_W][ax] ? $signed(-dq[Q_W][ax]) : $signed(dq[Q_W][ax]);
        end
      end
    end
  end

  // Output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || (en && vld[NSTG-1]);
      skid_valid <= 1'b0;
    end else if (en && vld[NSTG-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        point_x     <= sk_pt[0];
        point_y     <= sk_pt[1];
        point_z     <= sk_pt[2];
        point_valid <= sk_ok;
      end else begin
        point_x     <= fin_pt[0];
        point_y     <= fin_pt[1];
        point_z     <= fin_pt[2];
        point_valid <= fin_ok;
      end
    end else if (en) begin
      sk_pt <= fin_pt;
      sk_ok <= fin_ok;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tfp_check.sv @@
`default_nettype none

module tfp_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        pready,
  input logic [tfp_pkg::PADDR_W-1:0] paddr,
  input logic [tfp_pkg::APB_W-1:0]   prdata,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input tfp_pkg::org_t               point_x,
  input tfp_pkg::org_t               point_y,
  input tfp_pkg::org_t               point_z,
  input logic                        point_valid
);
  import tfp_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_z) && $stable(point_valid))
    else $error("output changed while stalled");

  // Near-parallel results carry a zero point
  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
    else $error("near-parallel result with nonzero point");

  // Input backpressure only while a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Reset empties the output and restores the threshold
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && pready
      && (paddr != REG_THR || prdata == APB_W'(THR_RESET)))
    else $error("bad state after reset");

endmodule

bind two_ray_fixation_point tfp_check u_tfp_check (.*);

`default_nettype wire
